// ===== src/brbe_pkg.sv =====
// Shared types and constants for the byte ring buffer engine.
package brbe_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int MAX_READ    = 64;
  localparam int WRITE_LANES = 8;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int QUEUE_DEPTH = 2;

  // Classified operation codes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_SKIP  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_PEEK  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] write_bytes;
    logic [3:0]  write_count;
    logic [6:0]  request_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        last;
    logic [6:0]  amount;
    logic [12:0] fill_level;
    logic [12:0] free_space;
    logic [12:0] contiguous_length;
    logic        is_full;
    logic        is_empty;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] data;
    logic [3:0]  wcnt;
    logic [6:0]  req;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== src/brbe_front.sv =====
// Front end: accepts commands and classifies them for the queue.
module brbe_front (
  input  logic              start,
  input  logic              busy,
  input  brbe_pkg::in_item_t cmd,
  output logic              push,
  output brbe_pkg::cmd_t    entry
);

  assign push = start & ~busy;

  // Fold unused opcodes into peek, clamp counts to their limits
  always_comb begin
    entry.data = cmd.write_bytes;
    if (cmd.opcode > brbe_pkg::OP_PEEK) begin
      entry.op = brbe_pkg::OP_PEEK;
    end else begin
      entry.op = cmd.opcode;
    end
    if (32'(cmd.write_count) > brbe_pkg::WRITE_LANES) begin
      entry.wcnt = 4'(brbe_pkg::WRITE_LANES);
    end else begin
      entry.wcnt = cmd.write_count;
    end
    if (32'(cmd.request_count) > brbe_pkg::MAX_READ) begin
      entry.req = 7'(brbe_pkg::MAX_READ);
    end else begin
      entry.req = cmd.request_count;
    end
  end

endmodule

// ===== src/brbe_queue.sv =====
// Short command queue between the front end and the execution back end.
module brbe_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  brbe_pkg::cmd_t           push_entry,
  input  logic                     pop,
  output brbe_pkg::cmd_t           pop_entry,
  output brbe_pkg::queue_status_t  stat
);

  localparam int PW = $clog2(brbe_pkg::QUEUE_DEPTH);

  brbe_pkg::cmd_t slots [brbe_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign stat.full  = (32'(count) == brbe_pkg::QUEUE_DEPTH);
  assign stat.empty = (count == '0);
  assign pop_entry  = slots[rd_ptr];

  // Pointer and occupancy tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == brbe_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == brbe_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== src/brbe_back.sv =====
// Back end: ring state, byte store and per-operation sequencer.
module brbe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_data,
  input  logic                q_empty,
  input  brbe_pkg::cmd_t      q_entry,
  output logic                q_pop,
  output logic                result_valid,
  output brbe_pkg::out_item_t result
);

  localparam int AW = brbe_pkg::ADDR_W;
  localparam int CW = brbe_pkg::CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]     state;
  logic [AW-1:0]  head;
  logic [AW-1:0]  tail;
  logic [CW-1:0]  fill;
  logic [CW-1:0]  cap;
  brbe_pkg::cmd_t cur;
  logic [6:0]     cnt;
  logic [6:0]     amt;
  logic [1:0]     emit_status;
  logic [AW-1:0]  rd_ptr;
  logic           rd_pend;
  logic           rd_pend_last;
  logic [7:0]     mem_q;
  logic [7:0]     store [brbe_pkg::STORE_DEPTH];

  logic [CW-1:0]  req_ext;
  logic [CW-1:0]  wcnt_ext;
  logic [CW-1:0]  n_take;
  logic [CW-1:0]  cap_minus_head;
  logic [CW-1:0]  contig;
  logic [CW-1:0]  cfg_cap;

  // Pointer step with wrap at the capacity in use
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] n,
                                        input logic [CW-1:0] c);
    logic [CW-1:0] room;
    room = c - {1'b0, p};
    if (n >= room) begin
      adv = AW'(n - room);
    end else begin
      adv = AW'({1'b0, p} + n);
    end
  endfunction

  assign req_ext        = CW'(cur.req);
  assign wcnt_ext       = CW'(cur.wcnt);
  assign n_take         = (req_ext < fill) ? req_ext : fill;
  assign cap_minus_head = cap - {1'b0, head};
  assign contig         = (fill < cap_minus_head) ? fill : cap_minus_head;
  assign q_pop          = (state == S_IDLE) && !q_empty;

  // Register value 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CW'(1);
    end else if (32'(cfg_data) > brbe_pkg::STORE_DEPTH) begin
      cfg_cap = CW'(brbe_pkg::STORE_DEPTH);
    end else begin
      cfg_cap = cfg_data;
    end
  end

  // Sequencer and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      cap     <= CW'(brbe_pkg::STORE_DEPTH);
      rd_pend <= 1'b0;
    end else if (cfg_we) begin
      cap     <= cfg_cap;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_entry;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          emit_status <= brbe_pkg::ST_OK;
          amt         <= '0;
          cnt         <= '0;
          state       <= S_EMIT;
          unique case (cur.op)
            brbe_pkg::OP_WRITE: begin
              if (cur.wcnt == '0) begin
                emit_status <= brbe_pkg::ST_OK;
              end else if (fill + wcnt_ext > cap) begin
                emit_status <= brbe_pkg::ST_OVF;
              end else begin
                amt   <= 7'(cur.wcnt);
                state <= S_WR;
              end
            end
            brbe_pkg::OP_READ: begin
              if (fill == '0) begin
                emit_status <= brbe_pkg::ST_EMPTY;
              end else if (n_take != '0) begin
                amt    <= 7'(n_take);
                rd_ptr <= head;
                head   <= adv(head, n_take, cap);
                fill   <= fill - n_take;
                state  <= S_RD;
              end
            end
            brbe_pkg::OP_SKIP: begin
              if (fill == '0) begin
                emit_status <= brbe_pkg::ST_EMPTY;
              end else begin
                amt  <= 7'(n_take);
                head <= adv(head, n_take, cap);
                fill <= fill - n_take;
              end
            end
            brbe_pkg::OP_CLEAR: begin
              head <= '0;
              tail <= '0;
              fill <= '0;
            end
            default: begin
            end
          endcase
        end
        S_WR: begin
          tail <= adv(tail, CW'(1), cap);
          cnt  <= cnt + 7'd1;
          if (cnt == 7'(cur.wcnt) - 7'd1) begin
            fill  <= fill + wcnt_ext;
            state <= S_EMIT;
          end
        end
        S_RD: begin
          rd_ptr       <= adv(rd_ptr, CW'(1), cap);
          cnt          <= cnt + 7'd1;
          rd_pend      <= 1'b1;
          rd_pend_last <= (cnt == amt - 7'd1);
          if (cnt == amt - 7'd1) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Byte store: at most one write plus one read per cycle, registered read data
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      store[tail] <= cur.data[{cnt[2:0], 3'b000} +: 8];
    end
    mem_q <= store[rd_ptr];
  end

  // Result register; status fields always reflect the ring after the operation
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_pend || (state == S_EMIT);
    end
    result.amount            <= amt;
    result.fill_level        <= fill;
    result.free_space        <= cap - fill;
    result.contiguous_length <= contig;
    result.is_full           <= (fill >= cap);
    result.is_empty          <= (fill == '0);
    if (rd_pend) begin
      result.status     <= brbe_pkg::ST_OK;
      result.byte_out   <= mem_q;
      result.byte_valid <= 1'b1;
      result.last       <= rd_pend_last;
    end else begin
      result.status     <= emit_status;
      result.byte_out   <= '0;
      result.byte_valid <= 1'b0;
      result.last       <= 1'b1;
    end
  end

endmodule

// ===== src/byte_ring_buffer_engine_core.sv =====
// Top level of the byte ring buffer engine.
//
//  channel   signals                        transaction
//  command   start, busy, cmd               start high while busy low
//  result    result_valid, result           result_valid high, one cycle, no stall
//  config    cfg_we, cfg_data               cfg_we high
//
// A command waits in a two-entry queue, then runs in the back end, which writes or reads
// its bytes one at a time through the byte store. busy is high while the queue is full.
// Reset (rst, synchronous) empties the ring and sets capacity to the store depth.
// Results cannot be held off by the receiver.
module byte_ring_buffer_engine_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  brbe_pkg::in_item_t  cmd,
  output logic                result_valid,
  output brbe_pkg::out_item_t result,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_data
);

  logic                    push;
  logic                    pop;
  brbe_pkg::cmd_t          push_entry;
  brbe_pkg::cmd_t          pop_entry;
  brbe_pkg::queue_status_t qstat;

  assign busy = qstat.full;

  brbe_front u_front (
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .push  (push),
    .entry (push_entry)
  );

  brbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (qstat)
  );

  brbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .q_empty      (qstat.empty),
    .q_entry      (pop_entry),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== src/brbe_checker.sv =====
// Port-level checks for the byte ring buffer engine, bound to the top level.
module brbe_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input brbe_pkg::out_item_t result
);

  // No result in the cycle after reset
  a_quiet_after_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  // A byte-carrying result is always a successful read
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.byte_valid) |-> (result.status == brbe_pkg::ST_OK))
    else $error("read byte with non-ok status");

  // Results without a byte close their transaction
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.byte_valid) |-> result.last)
    else $error("non-byte result without last");

  // Flags agree with the reported levels
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.is_empty == (result.fill_level == '0)) &&
                      (result.is_full == (result.free_space == '0))))
    else $error("full/empty flags disagree with levels");

  // A read stream keeps its amount until its last byte
  a_amount_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.byte_valid && !result.last) |=>
      (result_valid && result.byte_valid && $stable(result.amount)))
    else $error("read stream broken");

endmodule

bind byte_ring_buffer_engine_core brbe_checker u_brbe_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result       (result)
);

// ===== bench/ring_result_checker.sv =====
// Result checker for the byte ring buffer engine: mirrors the ring and compares results.
`timescale 1ns / 100ps

module ring_result_checker
  import brbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    cmd,
  input  logic        result_valid,
  input  out_item_t   result,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          waiting
);

  // Shadow copy of the ring
  logic [7:0] ring_mem [0:STORE_DEPTH-1];
  int         head_ptr;
  int         tail_ptr;
  int         fill_bytes;
  int         cap_reg;

  out_item_t  pending_results [$];
  out_item_t  oldest_expected;

  // Register value 0 behaves as 1, anything past the store depth as the depth
  function automatic int usable_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > STORE_DEPTH) return STORE_DEPTH;
    return cap_reg;
  endfunction

  // Status fields always reflect the state after the whole operation
  function automatic out_item_t ring_status(logic [1:0] st, logic [7:0] data_byte,
                                            logic has_byte, logic is_last, int amt);
    out_item_t r;
    int        cap;
    int        room;
    cap                 = usable_cap();
    room                = cap - head_ptr;
    r.status            = st;
    r.byte_out          = data_byte;
    r.byte_valid        = has_byte;
    r.last              = is_last;
    r.amount            = amt[6:0];
    r.fill_level        = fill_bytes[12:0];
    r.free_space        = 13'(cap - fill_bytes);
    r.contiguous_length = 13'((fill_bytes < room) ? fill_bytes : room);
    r.is_full           = (fill_bytes >= cap);
    r.is_empty          = (fill_bytes == 0);
    return r;
  endfunction

  function automatic string describe_result(out_item_t r);
    return $sformatf({"status=%0d byte=%02h valid=%0d last=%0d amount=%0d fill=%0d ",
                      "free=%0d contig=%0d full=%0d empty=%0d"},
                     r.status, r.byte_out, r.byte_valid, r.last, r.amount, r.fill_level,
                     r.free_space, r.contiguous_length, r.is_full, r.is_empty);
  endfunction

  // Advance the shadow ring by one command and queue its results
  task automatic apply_command(in_item_t c);
    logic [7:0] got_bytes [MAX_READ];
    int         cap;
    int         wcnt;
    int         req;
    int         n;
    cap  = usable_cap();
    wcnt = (c.write_count > WRITE_LANES) ? WRITE_LANES : int'(c.write_count);
    req  = (c.request_count > MAX_READ) ? MAX_READ : int'(c.request_count);
    case (c.opcode)
      OP_WRITE: begin
        if (wcnt == 0) begin
          pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, 0));
        end else if (fill_bytes + wcnt > cap) begin
          pending_results.push_back(ring_status(ST_OVF, 8'h00, 1'b0, 1'b1, 0));
        end else begin
          for (int i = 0; i < wcnt; i++) begin
            ring_mem[tail_ptr] = c.write_bytes[8*i +: 8];
            tail_ptr = (tail_ptr + 1 == cap) ? 0 : tail_ptr + 1;
          end
          fill_bytes += wcnt;
          pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, wcnt));
        end
      end
      OP_READ: begin
        if (fill_bytes == 0) begin
          pending_results.push_back(ring_status(ST_EMPTY, 8'h00, 1'b0, 1'b1, 0));
        end else begin
          n = (req < fill_bytes) ? req : fill_bytes;
          if (n == 0) begin
            pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, 0));
          end else begin
            for (int i = 0; i < n; i++) begin
              got_bytes[i] = ring_mem[head_ptr];
              head_ptr = (head_ptr + 1 == cap) ? 0 : head_ptr + 1;
            end
            fill_bytes -= n;
            for (int i = 0; i < n; i++)
              pending_results.push_back(ring_status(ST_OK, got_bytes[i], 1'b1,
                                                    (i == n - 1), n));
          end
        end
      end
      OP_SKIP: begin
        if (fill_bytes == 0) begin
          pending_results.push_back(ring_status(ST_EMPTY, 8'h00, 1'b0, 1'b1, 0));
        end else begin
          n = (req < fill_bytes) ? req : fill_bytes;
          head_ptr = (head_ptr + n) % cap;
          fill_bytes -= n;
          pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, n));
        end
      end
      OP_CLEAR: begin
        head_ptr   = 0;
        tail_ptr   = 0;
        fill_bytes = 0;
        pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, 0));
      end
      // peek and the unused codes only report status
      default: begin
        pending_results.push_back(ring_status(ST_OK, 8'h00, 1'b0, 1'b1, 0));
      end
    endcase
  endtask

  // Compare results first, then take in config writes and new commands
  always @(posedge clk) begin
    if (rst) begin
      head_ptr   = 0;
      tail_ptr   = 0;
      fill_bytes = 0;
      cap_reg    = STORE_DEPTH;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: %s", $realtime,
                     describe_result(result));
        end else begin
          oldest_expected = pending_results.pop_front();
          if ((result.status !== oldest_expected.status) ||
              (result.byte_out !== oldest_expected.byte_out) ||
              (result.byte_valid !== oldest_expected.byte_valid) ||
              (result.last !== oldest_expected.last) ||
              (result.amount !== oldest_expected.amount) ||
              (result.fill_level !== oldest_expected.fill_level) ||
              (result.free_space !== oldest_expected.free_space) ||
              (result.contiguous_length !== oldest_expected.contiguous_length) ||
              (result.is_full !== oldest_expected.is_full) ||
              (result.is_empty !== oldest_expected.is_empty)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", describe_result(oldest_expected));
              $display("  actual   %s", describe_result(result));
            end
          end
        end
      end
      // capacity write also empties the ring
      if (cfg_we) begin
        cap_reg    = int'(cfg_data);
        head_ptr   = 0;
        tail_ptr   = 0;
        fill_bytes = 0;
      end
      if (start && !busy)
        apply_command(cmd);
    end
    waiting = pending_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the byte ring buffer engine.
`timescale 1ns / 100ps

module testbench;
  import brbe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    cmd = '0;
  logic        result_valid;
  out_item_t   result;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_data = '0;
  int          mismatches;
  int          waiting;
  bit          idle_enabled = 1'b1;

  byte_ring_buffer_engine_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  ring_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .waiting      (waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Present one command and hold it until the block takes it
  task automatic send_item(in_item_t item);
    bit taken;
    cmd   <= item;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic issue(logic [2:0] op, logic [63:0] data, logic [3:0] wcnt,
                       logic [6:0] req);
    in_item_t item;
    item.opcode        = op;
    item.write_bytes   = data;
    item.write_count   = wcnt;
    item.request_count = req;
    send_item(item);
    maybe_idle();
  endtask

  // Drain every outstanding result, then write the capacity register
  task automatic program_capacity(logic [12:0] value);
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t random_item(int max_wc);
    in_item_t item;
    int       pick;
    int       r;
    pick             = $urandom_range(99);
    item.write_bytes = {$urandom, $urandom};
    if (pick < 45)      item.opcode = OP_WRITE;
    else if (pick < 70) item.opcode = OP_READ;
    else if (pick < 82) item.opcode = OP_SKIP;
    else if (pick < 85) item.opcode = OP_CLEAR;
    else if (pick < 93) item.opcode = OP_PEEK;
    else                item.opcode = OP_PEEK + 3'($urandom_range(1, 3));
    r = $urandom_range(99);
    if (r < 6)       item.write_count = '0;
    else if (r < 12) item.write_count = 4'($urandom_range(WRITE_LANES + 1, 15));
    else             item.write_count = 4'($urandom_range(1, max_wc));
    r = $urandom_range(99);
    if (r < 10)      item.request_count = 7'($urandom_range(MAX_READ + 1, 127));
    else if (r < 15) item.request_count = '0;
    else if (r < 60) item.request_count = 7'($urandom_range(1, 8));
    else             item.request_count = 7'($urandom_range(1, MAX_READ));
    return item;
  endfunction

  initial begin
    logic [12:0] phase_cap [7];
    int          phase_items [7];
    int          phase_wc [7];

    phase_cap   = '{13'd8191, 13'd1, 13'd0, 13'd13, 13'd100, 13'd2, 13'd4096};
    phase_items = '{60, 30, 20, 80, 100, 50, 60};
    phase_wc    = '{8, 1, 1, 8, 8, 8, 8};
    phase_cap[5] = 13'($urandom_range(2, 64));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, lane and request limits, unused codes
    issue(OP_PEEK,  64'h0, 4'd0, 7'd0);
    issue(OP_READ,  64'h0, 4'd0, 7'd5);
    issue(OP_SKIP,  64'h0, 4'd0, 7'd5);
    issue(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 7'd0);
    issue(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd127);
    issue(OP_WRITE, 64'h0, 4'd15, 7'd0);
    issue(OP_WRITE, 64'h0123_4567_89AB_CDEF, 4'd3, 7'd0);
    issue(OP_READ,  64'h0, 4'd0, 7'd0);
    issue(OP_READ,  64'h0, 4'd0, 7'd3);
    issue(OP_SKIP,  64'h0, 4'd0, 7'd2);
    issue(OP_READ,  64'h0, 4'd0, 7'd127);
    issue(OP_WRITE, 64'hA5A5_5A5A_0F0F_F0F0, 4'd8, 7'd0);
    issue(OP_SKIP,  64'h0, 4'd0, 7'd127);
    issue(OP_CLEAR, 64'h0, 4'd0, 7'd0);
    issue(OP_PEEK + 3'd1, 64'h0, 4'd0, 7'd0);
    issue(OP_PEEK + 3'd2, 64'h0, 4'd0, 7'd0);
    issue(OP_PEEK + 3'd3, 64'h0, 4'd0, 7'd0);

    // Directed: full ring, overflow and wrap on a tiny capacity
    program_capacity(13'd5);
    issue(OP_WRITE, 64'h0000_0055_4433_2211, 4'd5, 7'd0);
    issue(OP_PEEK,  64'h0, 4'd0, 7'd0);
    issue(OP_WRITE, 64'h0000_0000_0000_0066, 4'd1, 7'd0);
    issue(OP_READ,  64'h0, 4'd0, 7'd2);
    issue(OP_WRITE, 64'h0000_0000_0000_8877, 4'd2, 7'd0);
    issue(OP_PEEK,  64'h0, 4'd0, 7'd0);
    issue(OP_READ,  64'h0, 4'd0, 7'd64);
    issue(OP_WRITE, 64'h0000_0000_CCBB_AA99, 4'd4, 7'd0);

    // Random phases over a spread of capacities
    foreach (phase_cap[p]) begin
      program_capacity(phase_cap[p]);
      idle_enabled = (p != 4);
      for (int i = 0; i < phase_items[p]; i++) begin
        send_item(random_item(phase_wc[p]));
        maybe_idle();
      end
    end

    // Wind down and let any stray results show up
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
